[design/pitch_oscillator_friction_step_unit_defines.svh]
// ----------------------------------------------------------------------------
// pitch oscillator step unit: assertion macros
// Short forms for the concurrent checks of the step unit, clocked on clk and
// held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef PITCH_OSCILLATOR_FRICTION_STEP_UNIT_DEFINES_SVH
`define PITCH_OSCILLATOR_FRICTION_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define POFS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POFS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pofs_pkg.sv]
// ----------------------------------------------------------------------------
// pofs_pkg
// Number format, rounded constants, datapath selects and the microcode
// program of the pitch oscillator step unit.
// ----------------------------------------------------------------------------
package pofs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 24;
  localparam int CONST_FRAC = 48;
  localparam int PC_W       = 5;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  localparam data_t DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // constants with 48 fraction bits
  localparam logic signed [63:0] K_C1  = -64'sd19350799790;
  localparam logic signed [63:0] K_C2  = -64'sd5737197740000;
  localparam logic signed [63:0] K_C3  = -64'sd2047766463000;
  localparam logic signed [63:0] K_C4  = 64'sd10748924605000;
  localparam logic signed [63:0] K_C5  = 64'sd51341131788000;
  localparam logic signed [63:0] K_C6  = -64'sd70565521364000;
  localparam logic signed [63:0] K_THR = 64'sd1449236160000;

  localparam logic [63:0] MAX_MAG = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

  // round half away from zero down to FRAC_BITS, saturate
  function automatic data_t cq(input logic signed [63:0] k);
    logic [63:0] m;
    logic [63:0] r;
    m = k[63] ? (64'd0 - k) : k;
    r = (m + (64'd1 << (CONST_FRAC - FRAC_BITS - 1))) >> (CONST_FRAC - FRAC_BITS);
    if (k[63]) begin
      cq = (r > MAX_MAG) ? DMIN : data_t'(-r[DATA_WIDTH-1:0]);
    end else begin
      cq = (r > MAX_MAG) ? DMAX : data_t'(r[DATA_WIDTH-1:0]);
    end
  endfunction

  localparam data_t C1     = cq(K_C1);
  localparam data_t NEG_C1 = -C1;
  localparam data_t C2     = cq(K_C2);
  localparam data_t C3     = cq(K_C3);
  localparam data_t C4     = cq(K_C4);
  localparam data_t C5     = cq(K_C5);
  localparam data_t C6     = cq(K_C6);
  localparam data_t THR    = cq(K_THR);
  localparam data_t ONE    = data_t'(64'd1 << FRAC_BITS);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEFF_ANGLE, REG_COEFF_RATE, REG_COEFF_CUBE, REG_COEFF_SQUARE_RATE,
    REG_LAG_GAIN, REG_NOISE_SCALE, REG_TIME_STEP
  } reg_idx_t;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  // multiplier operand a
  typedef enum logic [3:0] {
    A_ANGLE, A_SQ, A_NSC, A_C2, A_DT, A_C3, A_C4, A_C5,
    A_E1, A_E2, A_E3, A_E4, A_FRIC, A_DTB, A_K6, A_LAG
  } asel_t;

  // multiplier operand b
  typedef enum logic [3:0] {
    B_ANGLE, B_NOISE, B_C6, B_LAG, B_RATE, B_MOMENT,
    B_CUBE, B_T, B_ACC, B_TGT, B_FORCE, B_ONE
  } bsel_t;

  // scratch register written by the adder stage
  typedef enum logic [3:0] {
    D_NONE, D_SQ, D_CUBE, D_FORCE, D_ACC, D_TGT,
    D_DTB, D_NA, D_NR, D_NM, D_T, D_K6
  } dsel_t;

  typedef enum logic [2:0] {
    BASE_ZERO, BASE_DST, BASE_ANGLE, BASE_RATE, BASE_MOMENT
  } base_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_NO_FRICTION, JMP_STOP
  } jmp_t;

  typedef enum logic [1:0] {
    FIN_NONE, FIN_STEP, FIN_LOAD
  } fin_t;

  typedef struct packed {
    asel_t a_sel;
    bsel_t b_sel;
    dsel_t dst;
    base_t base;
    logic  sub;
    jmp_t  jmp;
    fin_t  fin;
  } ucw_t;

  localparam logic [PC_W-1:0] PC_START = '0;
  localparam logic [PC_W-1:0] PC_LOAD  = PC_W'(22);

  function automatic ucw_t uw(input asel_t a, input bsel_t b, input dsel_t d,
                              input base_t bs, input logic sb, input jmp_t j,
                              input fin_t f);
    ucw_t w;
    w.a_sel = a;
    w.b_sel = b;
    w.dst   = d;
    w.base  = bs;
    w.sub   = sb;
    w.jmp   = j;
    w.fin   = f;
    return w;
  endfunction

  // one euler step; a product passes the multiply register and the adder stage before a later word can use it
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      5'd0:  w = uw(A_ANGLE, B_ANGLE,  D_SQ,    BASE_ZERO,   1'b0, JMP_NEXT, FIN_NONE);
      5'd1:  w = uw(A_NSC,   B_NOISE,  D_FORCE, BASE_ZERO,   1'b0, JMP_NEXT, FIN_NONE);
      5'd2:  w = uw(A_C2,    B_ANGLE,  D_ACC,   BASE_ZERO,   1'b0, JMP_NEXT, FIN_NONE);
      5'd3:  w = uw(A_DT,    B_C6,     D_K6,    BASE_ZERO,   1'b0, JMP_NEXT, FIN_NONE);
      5'd4:  w = uw(A_DT,    B_LAG,    D_DTB,   BASE_ZERO,   1'b0, JMP_NEXT, FIN_NONE);
      5'd5:  w = uw(A_DT,    B_RATE,   D_NA,    BASE_ANGLE,  1'b0, JMP_NEXT, FIN_NONE);
      5'd6:  w = uw(A_SQ,    B_ANGLE,  D_CUBE,  BASE_ZERO,   1'b0, JMP_NEXT, FIN_NONE);
      5'd7:  w = uw(A_C3,    B_RATE,   D_ACC,   BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd8:  w = uw(A_SQ,    B_RATE,   D_T,     BASE_ZERO,   1'b0, JMP_NEXT, FIN_NONE);
      5'd9:  w = uw(A_C4,    B_MOMENT, D_ACC,   BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd10: w = uw(A_E1,    B_ANGLE,  D_TGT,   BASE_ZERO,   1'b0, JMP_NEXT, FIN_NONE);
      5'd11: w = uw(A_C5,    B_CUBE,   D_ACC,   BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd12: w = uw(A_E2,    B_RATE,   D_TGT,   BASE_DST,    1'b0, JMP_NO_FRICTION,
                    FIN_NONE);
      5'd13: w = uw(A_FRIC,  B_ONE,    D_ACC,   BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd14: w = uw(A_E3,    B_CUBE,   D_TGT,   BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd15: w = uw(A_DT,    B_ACC,    D_NR,    BASE_RATE,   1'b0, JMP_NEXT, FIN_NONE);
      5'd16: w = uw(A_E4,    B_T,      D_TGT,   BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd17: w = uw(A_DTB,   B_MOMENT, D_NM,    BASE_MOMENT, 1'b1, JMP_NEXT, FIN_NONE);
      5'd18: w = uw(A_DTB,   B_TGT,    D_NM,    BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd19: w = uw(A_K6,    B_ACC,    D_NM,    BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd20: w = uw(A_LAG,   B_FORCE,  D_NM,    BASE_DST,    1'b0, JMP_NEXT, FIN_NONE);
      5'd21: w = uw(A_ANGLE, B_ANGLE,  D_NONE,  BASE_ZERO,   1'b0, JMP_STOP, FIN_STEP);
      5'd22: w = uw(A_ANGLE, B_ANGLE,  D_NONE,  BASE_ZERO,   1'b0, JMP_STOP, FIN_LOAD);
      default: w = uw(A_ANGLE, B_ANGLE, D_NONE, BASE_ZERO,   1'b0, JMP_STOP, FIN_NONE);
    endcase
    return w;
  endfunction

endpackage

[design/pitch_oscillator_friction_step_unit.sv]
// ----------------------------------------------------------------------------
// pitch_oscillator_friction_step_unit
// An advance item runs microcode words 0 to 21, skipping the friction word 13
// when the friction latch is clear, a load item word 22 alone; a new item is
// taken only once the last one has committed. One shared 32x32 multiplier is
// stepped by a 23-word microcode program, one multiply-accumulate per word.
// Reset (rst, synchronous) clears state, latch, configuration registers and valids.
// ----------------------------------------------------------------------------
`include "pitch_oscillator_friction_step_unit_defines.svh"

module pitch_oscillator_friction_step_unit
  import pofs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         write_enable,
  input  logic [2:0]                   write_index,
  input  logic [DATA_WIDTH-1:0]        write_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic signed [DATA_WIDTH-1:0] noise_sample,
  input  logic signed [DATA_WIDTH-1:0] load_angle,
  input  logic signed [DATA_WIDTH-1:0] load_rate,
  input  logic signed [DATA_WIDTH-1:0] load_moment,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] next_angle,
  output logic signed [DATA_WIDTH-1:0] next_rate,
  output logic signed [DATA_WIDTH-1:0] next_moment,
  output logic signed [DATA_WIDTH-1:0] forcing,
  output logic                         friction_on
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int MAG_W  = PROD_W - FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // configuration registers
  data_t                 coeff_angle, coeff_rate, coeff_cube, coeff_square_rate;
  data_t                 lag_gain, noise_scale;
  logic [DATA_WIDTH-2:0] time_step;

  // state
  data_t angle, rate, moment;
  logic  latched;

  // held input fields
  data_t noise, ld_angle, ld_rate, ld_moment;

  // scratch registers
  data_t sq, cube, noise_force, acc, tgt, dtb, na, nr, nm, t, k6;

  // sequencer
  logic            run;
  logic [PC_W-1:0] pc;
  ucw_t            word;

  // multiply stage
  logic                  s2_valid;
  ucw_t                  s2_word;
  logic [PROD_W-1:0]     prod;
  logic                  prod_neg;

  data_t                 op_a, op_b, dt_op;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [PROD_W-1:0]     rnd;
  logic [MAG_W-1:0]      mag;
  logic                  mag_ovf;
  data_t                 prod_s, base_v, alu_out;
  logic [DATA_WIDTH+1:0] sum;
  logic                  hold, accept, commit;

  assign word   = ucode(pc);
  assign dt_op  = data_t'({1'b0, time_step});
  assign accept = in_valid && !in_stall;
  assign in_stall = run || s2_valid;
  // a finished step waits while the previous result is still unclaimed
  assign hold   = s2_valid && (s2_word.fin != FIN_NONE) && out_valid && out_stall;
  assign commit = s2_valid && (s2_word.fin != FIN_NONE) && !hold;

  always_comb begin
    unique case (word.a_sel)
      A_ANGLE: op_a = angle;
      A_SQ:    op_a = sq;
      A_NSC:   op_a = noise_scale;
      A_C2:    op_a = C2;
      A_DT:    op_a = dt_op;
      A_C3:    op_a = C3;
      A_C4:    op_a = C4;
      A_C5:    op_a = C5;
      A_E1:    op_a = coeff_angle;
      A_E2:    op_a = coeff_rate;
      A_E3:    op_a = coeff_cube;
      A_E4:    op_a = coeff_square_rate;
      A_FRIC:  op_a = (rate > 0) ? C1 : NEG_C1;
      A_DTB:   op_a = dtb;
      A_K6:    op_a = k6;
      A_LAG:   op_a = lag_gain;
      default: op_a = angle;
    endcase
  end

  always_comb begin
    unique case (word.b_sel)
      B_ANGLE:  op_b = angle;
      B_NOISE:  op_b = noise;
      B_C6:     op_b = C6;
      B_LAG:    op_b = lag_gain;
      B_RATE:   op_b = rate;
      B_MOMENT: op_b = moment;
      B_CUBE:   op_b = cube;
      B_T:      op_b = t;
      B_ACC:    op_b = acc;
      B_TGT:    op_b = tgt;
      B_FORCE:  op_b = noise_force;
      B_ONE:    op_b = ONE;
      default:  op_b = angle;
    endcase
  end

  assign mag_a = op_a[DATA_WIDTH-1] ? $unsigned(-op_a) : $unsigned(op_a);
  assign mag_b = op_b[DATA_WIDTH-1] ? $unsigned(-op_b) : $unsigned(op_b);

  // round half away from zero, then saturate on the magnitude
  assign rnd     = prod + HALF;
  assign mag     = rnd[PROD_W-1:FRAC_BITS];
  assign mag_ovf = |mag[MAG_W-1:DATA_WIDTH-1];

  always_comb begin
    if (mag_ovf) begin
      prod_s = prod_neg ? DMIN : DMAX;
    end else if (prod_neg) begin
      prod_s = data_t'(-mag[DATA_WIDTH-1:0]);
    end else begin
      prod_s = data_t'(mag[DATA_WIDTH-1:0]);
    end
  end

  always_comb begin
    unique case (s2_word.base)
      BASE_ZERO:   base_v = '0;
      BASE_ANGLE:  base_v = angle;
      BASE_RATE:   base_v = rate;
      BASE_MOMENT: base_v = moment;
      BASE_DST: begin
        unique case (s2_word.dst)
          D_SQ:    base_v = sq;
          D_CUBE:  base_v = cube;
          D_FORCE: base_v = noise_force;
          D_ACC:   base_v = acc;
          D_TGT:   base_v = tgt;
          D_DTB:   base_v = dtb;
          D_NA:    base_v = na;
          D_NR:    base_v = nr;
          D_NM:    base_v = nm;
          D_T:     base_v = t;
          D_K6:    base_v = k6;
          default: base_v = '0;
        endcase
      end
      default:     base_v = '0;
    endcase
  end

  // saturating add or subtract with two guard bits
  always_comb begin
    if (s2_word.sub) begin
      sum = {{2{base_v[DATA_WIDTH-1]}}, base_v} - {{2{prod_s[DATA_WIDTH-1]}}, prod_s};
    end else begin
      sum = {{2{base_v[DATA_WIDTH-1]}}, base_v} + {{2{prod_s[DATA_WIDTH-1]}}, prod_s};
    end
    if (sum[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b000 ||
        sum[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b111) begin
      alu_out = data_t'(sum[DATA_WIDTH-1:0]);
    end else begin
      alu_out = sum[DATA_WIDTH+1] ? DMIN : DMAX;
    end
  end

  // control, configuration and state
  always_ff @(posedge clk) begin
    if (rst) begin
      run               <= 1'b0;
      pc                <= PC_START;
      s2_valid          <= 1'b0;
      out_valid         <= 1'b0;
      latched           <= 1'b0;
      angle             <= '0;
      rate              <= '0;
      moment            <= '0;
      coeff_angle       <= '0;
      coeff_rate        <= '0;
      coeff_cube        <= '0;
      coeff_square_rate <= '0;
      lag_gain          <= '0;
      noise_scale       <= '0;
      time_step         <= '0;
    end else begin
      if (write_enable) begin
        unique case (write_index)
          REG_COEFF_ANGLE:       coeff_angle       <= write_data;
          REG_COEFF_RATE:        coeff_rate        <= write_data;
          REG_COEFF_CUBE:        coeff_cube        <= write_data;
          REG_COEFF_SQUARE_RATE: coeff_square_rate <= write_data;
          REG_LAG_GAIN:          lag_gain          <= write_data;
          REG_NOISE_SCALE:       noise_scale       <= write_data;
          REG_TIME_STEP:         time_step         <= write_data[DATA_WIDTH-2:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && !commit) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        run <= 1'b1;
        pc  <= (operation == OP_LOAD) ? PC_LOAD : PC_START;
        // latch is tested on the angle before the step
        if (operation == OP_ADVANCE && (angle > THR || angle < -THR)) begin
          latched <= 1'b1;
        end
      end else if (run) begin
        unique case (word.jmp)
          JMP_NEXT:        pc  <= pc + PC_W'(1);
          JMP_NO_FRICTION: pc  <= latched ? pc + PC_W'(1) : pc + PC_W'(2);
          JMP_STOP:        run <= 1'b0;
          default:         run <= 1'b0;
        endcase
      end

      if (!hold) begin
        s2_valid <= run;
      end

      if (commit) begin
        out_valid <= 1'b1;
        if (s2_word.fin == FIN_LOAD) begin
          angle  <= ld_angle;
          rate   <= ld_rate;
          moment <= ld_moment;
        end else begin
          angle  <= na;
          rate   <= nr;
          moment <= nm;
        end
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      noise     <= noise_sample;
      ld_angle  <= load_angle;
      ld_rate   <= load_rate;
      ld_moment <= load_moment;
    end

    if (!hold) begin
      s2_word  <= word;
      prod     <= mag_a * mag_b;
      prod_neg <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
    end

    if (s2_valid && !hold) begin
      case (s2_word.dst)
        D_SQ:    sq          <= alu_out;
        D_CUBE:  cube        <= alu_out;
        D_FORCE: noise_force <= alu_out;
        D_ACC:   acc         <= alu_out;
        D_TGT:   tgt         <= alu_out;
        D_DTB:   dtb         <= alu_out;
        D_NA:    na          <= alu_out;
        D_NR:    nr          <= alu_out;
        D_NM:    nm          <= alu_out;
        D_T:     t           <= alu_out;
        D_K6:    k6          <= alu_out;
        default: ;
      endcase
    end

    if (commit) begin
      friction_on <= latched;
      if (s2_word.fin == FIN_LOAD) begin
        next_angle  <= ld_angle;
        next_rate   <= ld_rate;
        next_moment <= ld_moment;
        forcing     <= '0;
      end else begin
        next_angle  <= na;
        next_rate   <= nr;
        next_moment <= nm;
        forcing     <= noise_force;
      end
    end
  end

  `POFS_ASSERT_NXT(a_latch_sticky, latched, latched, "friction latch cleared")
  `POFS_ASSERT_NXT(a_accept_starts, accept, run && !s2_valid, "accepted item did not start")
  `POFS_ASSERT_IMP(a_fin_drained, s2_valid && s2_word.fin != FIN_NONE, !run,
                   "sequencer still issuing at commit")
  `POFS_ASSERT_NXT(a_commit_held, hold, s2_valid && out_valid,
                   "waiting result lost before hand-off")

endmodule

[bench/pitch_oscillator_friction_step_unit_tb.sv]
// ----------------------------------------------------------------------------
// pitch_oscillator_friction_step_unit_tb
// Drives advance and load items through the step unit under random sender
// gaps and receiver stalls. A bit-exact Q8.24 copy of the oscillator step
// predicts every result, and a monitor checks each one field by field.
// ----------------------------------------------------------------------------
module pitch_oscillator_friction_step_unit_tb;
  import pofs_pkg::*;

  localparam int Q_FRAC         = 24;
  localparam int CONST_SHIFT    = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 135;

  localparam logic [2:0] REG_SPARE_INDEX = 3'd7;

  localparam data_t Q_MAX = data_t'(32'h7fff_ffff);
  localparam data_t Q_MIN = data_t'(32'h8000_0000);

  // oscillator constants, 48 fraction bits
  localparam longint FRIC_K48   = -64'sd19350799790;
  localparam longint STIFF_K48  = -64'sd5737197740000;
  localparam longint DAMP_K48   = -64'sd2047766463000;
  localparam longint MOMENT_K48 = 64'sd10748924605000;
  localparam longint CUBIC_K48  = 64'sd51341131788000;
  localparam longint LAG_K48    = -64'sd70565521364000;
  localparam longint THRESH_K48 = 64'sd1449236160000;

  typedef struct {
    data_t angle;
    data_t rate;
    data_t moment;
    data_t forcing;
    logic  friction;
  } step_result_t;

  function automatic data_t q_round_const(input longint k);
    longint unsigned mag;
    mag = (k < 0) ? -k : k;
    mag = (mag + (64'd1 << (CONST_SHIFT - 1))) >> CONST_SHIFT;
    return (k < 0) ? data_t'(-longint'(mag)) : data_t'(mag);
  endfunction

  localparam data_t FRIC_Q   = q_round_const(FRIC_K48);
  localparam data_t STIFF_Q  = q_round_const(STIFF_K48);
  localparam data_t DAMP_Q   = q_round_const(DAMP_K48);
  localparam data_t MOMENT_Q = q_round_const(MOMENT_K48);
  localparam data_t CUBIC_Q  = q_round_const(CUBIC_K48);
  localparam data_t LAG_Q    = q_round_const(LAG_K48);
  localparam data_t THRESH_Q = q_round_const(THRESH_K48);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  write_enable = 1'b0;
  logic [2:0]            write_index = '0;
  logic [DATA_WIDTH-1:0] write_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  operation = 1'b0;
  data_t                 noise_sample = '0;
  data_t                 load_angle = '0;
  data_t                 load_rate = '0;
  data_t                 load_moment = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  data_t                 next_angle;
  data_t                 next_rate;
  data_t                 next_moment;
  data_t                 forcing;
  logic                  friction_on;

  // predicted oscillator state and register copies
  data_t      st_angle = '0;
  data_t      st_rate = '0;
  data_t      st_moment = '0;
  logic       st_latch = 1'b0;
  data_t      gain_angle = '0;
  data_t      gain_rate = '0;
  data_t      gain_cube = '0;
  data_t      gain_sq_rate = '0;
  data_t      lag_rate = '0;
  data_t      noise_gain = '0;
  logic [30:0] step_size = '0;

  step_result_t pending_states[$];
  int           mismatches = 0;
  int           burst_left = 0;
  bit           valid_held = 1'b0;
  int           idle_cycles = 0;

  pitch_oscillator_friction_step_unit dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .noise_sample (noise_sample),
    .load_angle   (load_angle),
    .load_rate    (load_rate),
    .load_moment  (load_moment),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .next_angle   (next_angle),
    .next_rate    (next_rate),
    .next_moment  (next_moment),
    .forcing      (forcing),
    .friction_on  (friction_on)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // product rounded half away from zero, saturated
  function automatic data_t q_mul(input data_t a, input data_t b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    logic            neg;
    ma = a[DATA_WIDTH-1] ? -longint'(a) : longint'(a);
    mb = b[DATA_WIDTH-1] ? -longint'(b) : longint'(b);
    neg = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    p = (ma * mb + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
    if (neg) begin
      return (p >= 64'h8000_0000) ? Q_MIN : data_t'(-longint'(p));
    end
    return (p > 64'h7fff_ffff) ? Q_MAX : data_t'(p);
  endfunction

  function automatic data_t q_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > longint'(Q_MAX)) return Q_MAX;
    if (s < longint'(Q_MIN)) return Q_MIN;
    return data_t'(s);
  endfunction

  function automatic step_result_t model_item(input op_t op, input data_t noise,
                                              input data_t la, input data_t lr,
                                              input data_t lm);
    step_result_t r;
    data_t dt, sq, cube, forcing_v, acc, tgt, dtb, na, nr, nm;
    dt = data_t'({1'b0, step_size});
    forcing_v = '0;
    if (op == OP_LOAD) begin
      st_angle = la;
      st_rate = lr;
      st_moment = lm;
    end else begin
      if (st_angle > THRESH_Q || st_angle < -THRESH_Q) st_latch = 1'b1;
      sq = q_mul(st_angle, st_angle);
      cube = q_mul(sq, st_angle);
      forcing_v = q_mul(noise_gain, noise);
      acc = q_mul(STIFF_Q, st_angle);
      acc = q_add(acc, q_mul(DAMP_Q, st_rate));
      acc = q_add(acc, q_mul(MOMENT_Q, st_moment));
      acc = q_add(acc, q_mul(CUBIC_Q, cube));
      // zero rate takes the negative sign
      if (st_latch) acc = q_add(acc, (st_rate > 0) ? FRIC_Q : -FRIC_Q);
      na = q_add(st_angle, q_mul(dt, st_rate));
      nr = q_add(st_rate, q_mul(dt, acc));
      tgt = q_mul(gain_angle, st_angle);
      tgt = q_add(tgt, q_mul(gain_rate, st_rate));
      tgt = q_add(tgt, q_mul(gain_cube, cube));
      tgt = q_add(tgt, q_mul(gain_sq_rate, q_mul(sq, st_rate)));
      dtb = q_mul(dt, lag_rate);
      nm = q_add(st_moment, -longint'(q_mul(dtb, st_moment)));
      nm = q_add(nm, q_mul(dtb, tgt));
      nm = q_add(nm, q_mul(q_mul(dt, LAG_Q), acc));
      nm = q_add(nm, q_mul(lag_rate, forcing_v));
      st_angle = na;
      st_rate = nr;
      st_moment = nm;
    end
    r.angle = st_angle;
    r.rate = st_rate;
    r.moment = st_moment;
    r.forcing = forcing_v;
    r.friction = st_latch;
    return r;
  endfunction

  // signed value within +-2^(bits-1) lsb
  function automatic data_t rand_small(input int bits);
    data_t v;
    v = data_t'($urandom);
    return v >>> (DATA_WIDTH - bits);
  endfunction

  function automatic data_t rand_field();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2, 3, 4: return data_t'($urandom);
      default: return rand_small($urandom_range(4, 30));
    endcase
  endfunction

  task automatic send_item(input op_t op, input data_t noise, input data_t la,
                           input data_t lr, input data_t lm);
    if (burst_left == 0) begin
      if (valid_held) begin
        in_valid <= 1'b0;
        valid_held = 1'b0;
      end
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
    operation <= op;
    noise_sample <= noise;
    load_angle <= la;
    load_rate <= lr;
    load_moment <= lm;
    if (!valid_held) begin
      in_valid <= 1'b1;
      valid_held = 1'b1;
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_states.push_back(model_item(op, noise, la, lr, lm));
    burst_left--;
  endtask

  // sender holds off until every predicted state has come back
  task automatic drain_results();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
    burst_left = 0;
    while (pending_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_WIDTH-1:0] value);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= value;
    @(posedge clk);
    case (idx)
      REG_COEFF_ANGLE:       gain_angle = data_t'(value);
      REG_COEFF_RATE:        gain_rate = data_t'(value);
      REG_COEFF_CUBE:        gain_cube = data_t'(value);
      REG_COEFF_SQUARE_RATE: gain_sq_rate = data_t'(value);
      REG_LAG_GAIN:          lag_rate = data_t'(value);
      REG_NOISE_SCALE:       noise_gain = data_t'(value);
      REG_TIME_STEP:         step_size = value[30:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input data_t ga, input data_t gr, input data_t gc,
                                input data_t gs, input data_t lg, input data_t ns,
                                input logic [DATA_WIDTH-1:0] ts);
    drain_results();
    write_reg(REG_COEFF_ANGLE, ga);
    write_reg(REG_COEFF_RATE, gr);
    write_reg(REG_COEFF_CUBE, gc);
    write_reg(REG_COEFF_SQUARE_RATE, gs);
    write_reg(REG_LAG_GAIN, lg);
    write_reg(REG_NOISE_SCALE, ns);
    write_reg(REG_TIME_STEP, ts);
    write_enable <= 1'b0;
  endtask

  // gains of order one, small time step
  task automatic apply_typical_settings();
    apply_settings(rand_small(26), rand_small(26), rand_small(26), rand_small(26),
                   rand_small(25), rand_small(22), $urandom_range(1 << 14, 1 << 21));
  endtask

  task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] want_v,
                             input logic [DATA_WIDTH-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    step_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_states.size() == 0) begin
        $display("%0t: result with no item pending: expected none, actual %h %h %h %h %b",
                 $time, next_angle, next_rate, next_moment, forcing, friction_on);
        mismatches++;
      end else begin
        want = pending_states.pop_front();
        check_field("next_angle", want.angle, next_angle);
        check_field("next_rate", want.rate, next_rate);
        check_field("next_moment", want.moment, next_moment);
        check_field("forcing", want.forcing, forcing);
        check_field("friction_on", want.friction, friction_on);
      end
    end
  end

  initial begin : receiver_stalls
    int free_run;
    int hold;
    forever begin
      free_run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 12);
      hold = $urandom_range(1, 8);
      out_stall <= 1'b0;
      repeat (free_run) @(posedge clk);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("pitch_oscillator_friction_step_unit test failed");
    $finish;
  end

  // registers and state all zero after reset
  task automatic test_reset_defaults();
    send_item(OP_ADVANCE, Q_MAX, data_t'($urandom), data_t'($urandom), data_t'($urandom));
    send_item(OP_ADVANCE, Q_MIN, data_t'($urandom), data_t'($urandom), data_t'($urandom));
  endtask

  // latch must stay clear while |angle| is at or under the threshold
  task automatic test_below_threshold();
    apply_typical_settings();
    send_item(OP_LOAD, rand_small(27), THRESH_Q, '0, rand_small(20));
    send_item(OP_ADVANCE, rand_small(27), rand_field(), rand_field(), rand_field());
    send_item(OP_LOAD, rand_small(27), -THRESH_Q, rand_small(12), rand_small(20));
    send_item(OP_ADVANCE, rand_small(27), rand_field(), rand_field(), rand_field());
    send_item(OP_LOAD, rand_small(27), '0, data_t'($urandom_range(1, 1 << 10)), '0);
    send_item(OP_ADVANCE, rand_small(27), rand_field(), rand_field(), rand_field());
    send_item(OP_ADVANCE, rand_small(27), rand_field(), rand_field(), rand_field());
  endtask

  task automatic test_ignored_write();
    drain_results();
    write_reg(REG_SPARE_INDEX, $urandom);
    write_enable <= 1'b0;
    send_item(OP_LOAD, rand_small(27), rand_small(16), rand_small(16), rand_small(20));
    send_item(OP_ADVANCE, rand_small(27), rand_field(), rand_field(), rand_field());
  endtask

  // one lsb over the threshold sets the latch for the rest of the run
  task automatic test_friction_latch();
    send_item(OP_LOAD, rand_small(27), data_t'(THRESH_Q + 1), '0, rand_small(20));
    send_item(OP_ADVANCE, rand_small(27), rand_field(), rand_field(), rand_field());
    send_item(OP_LOAD, rand_small(27), '0, data_t'($urandom_range(1, 1 << 20)), '0);
    send_item(OP_ADVANCE, rand_small(27), rand_field(), rand_field(), rand_field());
    send_item(OP_LOAD, rand_small(27), '0, -data_t'($urandom_range(1, 1 << 20)), '0);
    send_item(OP_ADVANCE, rand_small(27), rand_field(), rand_field(), rand_field());
  endtask

  task automatic test_saturation();
    // bit 31 of the time step write is dropped
    apply_settings(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'hffff_ffff);
    send_item(OP_LOAD, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    send_item(OP_ADVANCE, Q_MAX, rand_field(), rand_field(), rand_field());
    send_item(OP_LOAD, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    send_item(OP_ADVANCE, Q_MIN, rand_field(), rand_field(), rand_field());
    apply_settings(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 32'h8000_0000);
    send_item(OP_LOAD, Q_MAX, Q_MAX, Q_MIN, Q_MAX);
    send_item(OP_ADVANCE, Q_MIN, rand_field(), rand_field(), rand_field());
    send_item(OP_LOAD, Q_MIN, Q_MIN, Q_MAX, Q_MIN);
    send_item(OP_ADVANCE, Q_MAX, rand_field(), rand_field(), rand_field());
  endtask

  // mostly load-then-run trajectories, some arbitrary items in between
  task automatic test_random_trajectories();
    int sent;
    int run;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 2) != 0) begin
        apply_typical_settings();
      end else begin
        apply_settings(data_t'($urandom), data_t'($urandom), data_t'($urandom),
                       data_t'($urandom), data_t'($urandom), data_t'($urandom), $urandom);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          8: begin
            send_item(op_t'($urandom_range(0, 1)), data_t'($urandom), rand_field(),
                      rand_field(), rand_field());
            run = 0;
          end
          9: begin
            send_item(OP_LOAD, data_t'($urandom), rand_field(), rand_field(), rand_field());
            run = $urandom_range(1, 4);
          end
          default: begin
            send_item(OP_LOAD, data_t'($urandom), rand_small(22), rand_small(22),
                      rand_small(24));
            run = $urandom_range(4, 30);
          end
        endcase
        sent++;
        repeat (run) begin
          send_item(OP_ADVANCE, ($urandom_range(0, 7) == 0) ? rand_field() : rand_small(27),
                    data_t'($urandom), data_t'($urandom), data_t'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_below_threshold();
    test_ignored_write();
    test_friction_latch();
    test_saturation();
    test_random_trajectories();
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_states.size() == 0) begin
      $display("pitch_oscillator_friction_step_unit test passed");
    end else begin
      $display("pitch_oscillator_friction_step_unit test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/pofs_pkg.sv
design/pitch_oscillator_friction_step_unit.sv
bench/pitch_oscillator_friction_step_unit_tb.sv
